// ----- hdl/bce_pkg.sv -----
// Package for binary cross-entropy loss and gradient: constants, log2 table.
package bce_pkg;
  localparam int unsigned MaxLen = 1024;
  localparam int unsigned LenW = 11;
  localparam logic [15:0] OneQ15 = 16'd32768;
  localparam logic [16:0] Ln2Q16 = 17'd45426;
  localparam logic [39:0] SumMax = 40'hFF_FFFF_FFFF;
  localparam logic [LenW-1:0] MaxLenC = LenW'(MaxLen);

  typedef enum logic [0:0] {
    RegVectorLength = 1'b0
  } reg_idx_e;

  typedef logic [64:0][16:0] log_tab_t;

  // log2(1 + i/64) in Q.16 by repeated squaring in Q2.30, truncating
  function automatic log_tab_t gen_log_tab();
    log_tab_t    tab;
    logic [63:0] z;
    logic [16:0] r;
    for (int i = 0; i < 64; i++) begin
      z = 64'(64 + i) << 24;
      r = '0;
      for (int k = 0; k < 16; k++) begin
        z = (z * z) >> 30;
        r = {r[15:0], 1'b0};
        if (z >= 64'h0000_0000_8000_0000) begin
          z = z >> 1;
          r[0] = 1'b1;
        end
      end
      tab[i] = r;
    end
    tab[64] = 17'd65536;
    return tab;
  endfunction

  localparam log_tab_t LogTab = gen_log_tab();

  function automatic logic [16:0] log_tab(input logic [6:0] i);
    return LogTab[i];
  endfunction
endpackage

// ----- hdl/binary_cross_entropy_loss_grad.sv -----
// Binary cross-entropy loss and gradient, one radix-2 divider under a sequencer.
// Each element runs three 40-step divisions and two log passes, each pass opened by an
// msb search; the last element adds a 40-step loss division. One transaction in flight;
// the next is taken the cycle after the result is accepted. Reset (rst_ni low,
// asynchronous) sets the length to 1 and clears the element count and the running sum.
module binary_cross_entropy_loss_grad (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // predicted_value[15:0], target_value[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // gradient[31:0], loss[55:32]
  output logic        m_axis_tuser,   // loss_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIVA, S_DIVB, S_GRAD, S_DIVG, S_LOG1, S_LOG2, S_LOG3, S_LOGM,
    S_TERM, S_SUM, S_DIVL, S_OUT
  } state_e;

  state_e            state_q;
  logic [bce_pkg::LenW-1:0] len_q, cnt_q, n_q;
  logic [39:0]       sum_q;
  logic [15:0]       t_q, p_q;
  logic              side_q;          // 0: p / t, 1: q / u
  logic [31:0]       a_q;
  logic              neg_q;
  logic [31:0]       grad_q;
  logic [31:0]       nlp_q;
  logic [63:0]       acc_q;
  logic [39:0]       num_q;           // divider quotient / dividend shift
  logic [40:0]       rem_q;
  logic [28:0]       den_q;
  logic [5:0]        bit_q;
  logic [3:0]        e_q;
  logic [16:0]       l2_q;
  logic              ov_q;
  logic              ovalid_q;
  logic [31:0]       ograd_q;
  logic [23:0]       oloss_q;
  logic              olast_q;

  wire wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, len_q} : 32'd0;
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {oloss_q, ograd_q};
  assign m_axis_tuser = olast_q;

  logic [15:0] pin, tin;
  always_comb begin
    pin = s_axis_tdata[15:0];
    tin = s_axis_tdata[31:16];
    if (pin == 16'd0) pin = 16'd1;
    if (pin > 16'd32767) pin = 16'd32767;
    if (tin > bce_pkg::OneQ15) tin = bce_pkg::OneQ15;
  end

  // divider step
  logic [40:0] rsh;
  logic        dge;
  always_comb begin
    rsh = {rem_q[39:0], num_q[39]};
    dge = rsh >= {12'd0, den_q};
  end

  // log operand
  logic [15:0] lx;
  assign lx = side_q ? (bce_pkg::OneQ15 - p_q) : p_q;
  logic [15:0] m_norm;
  assign m_norm = lx << (4'd15 - e_q);
  logic [16:0] tj, tj1;
  assign tj = bce_pkg::log_tab({1'b0, m_norm[14:9]});
  assign tj1 = bce_pkg::log_tab({1'b0, m_norm[14:9]} + 7'd1);

  logic [bce_pkg::LenW-1:0] n_eff;
  always_comb begin
    n_eff = len_q;
    if (n_eff == '0) n_eff = bce_pkg::LenW'(1);
    if (n_eff > bce_pkg::MaxLenC) n_eff = bce_pkg::MaxLenC;
  end

  logic [32:0] diff;
  logic [40:0] sumn;
  always_comb begin
    diff = {1'b0, num_q[31:0]} - {1'b0, a_q};
    sumn = {1'b0, sum_q} + {1'b0, acc_q[46:7]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= 11'd1;
      cnt_q <= '0;
      sum_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (wr && paddr[2] == 1'b0) len_q <= pwdata[bce_pkg::LenW-1:0];
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          p_q <= pin; t_q <= tin; n_q <= n_eff;
          num_q <= {8'd0, tin, 16'd0}; rem_q <= '0;
          den_q <= {13'd0, pin}; bit_q <= 6'd40;
          state_q <= S_DIVA;
        end
        S_DIVA, S_DIVB, S_DIVG, S_DIVL: begin
          if (bit_q != 6'd1) begin
            rem_q <= dge ? rsh - {12'd0, den_q} : rsh;
            num_q <= {num_q[38:0], dge};
            bit_q <= bit_q - 6'd1;
          end else if (state_q == S_DIVA) begin
            a_q <= {num_q[30:0], dge};
            num_q <= {8'd0, bce_pkg::OneQ15 - t_q, 16'd0}; rem_q <= '0;
            den_q <= {13'd0, bce_pkg::OneQ15 - p_q}; bit_q <= 6'd40;
            state_q <= S_DIVB;
          end else if (state_q == S_DIVB) begin
            num_q <= {num_q[38:0], dge};
            state_q <= S_GRAD;
          end else if (state_q == S_DIVG) begin
            grad_q <= {num_q[30:0], dge};
            ov_q <= |num_q[38:31];
            side_q <= 1'b0; e_q <= 4'd15; acc_q <= '0;
            state_q <= S_LOG1;
          end else begin
            ograd_q <= grad_q;
            oloss_q <= (|num_q[38:23]) ? 24'hFF_FFFF : {num_q[22:0], dge};
            olast_q <= 1'b1; ovalid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_GRAD: begin
          neg_q <= diff[32];
          num_q <= {7'd0, diff[32] ? (33'd0 - diff) : diff};
          rem_q <= '0; den_q <= {18'd0, n_q}; bit_q <= 6'd40;
          state_q <= S_DIVG;
        end
        S_LOG1: begin
          // msb search, one bit per cycle from the top
          if (lx[e_q] || e_q == 4'd0) state_q <= S_LOG2;
          else e_q <= e_q - 4'd1;
        end
        S_LOG2: begin
          l2_q <= tj + 17'((34'(tj1 - tj) * 34'(m_norm[8:0])) >> 9);
          state_q <= S_LOG3;
        end
        S_LOG3: begin
          // magnitude = (15-e)*65536 - L, always >= 0
          nlp_q <= {12'd0, 4'd15 - e_q, 16'd0} - {15'd0, l2_q};
          state_q <= S_LOGM;
        end
        S_LOGM: begin
          nlp_q <= 32'((48'(nlp_q[20:0]) * 48'(bce_pkg::Ln2Q16) + 48'd32768) >> 16);
          state_q <= S_TERM;
        end
        S_TERM: begin
          acc_q <= acc_q + 64'(nlp_q[19:0]) *
                   64'(side_q ? (bce_pkg::OneQ15 - t_q) : t_q);
          if (!side_q) begin
            side_q <= 1'b1; e_q <= 4'd15; state_q <= S_LOG1;
          end else state_q <= S_SUM;
        end
        S_SUM: begin
          logic [39:0] s;
          s = sumn[40] ? bce_pkg::SumMax : sumn[39:0];
          if (ov_q) grad_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else if (!neg_q && grad_q[31]) grad_q <= 32'h7FFF_FFFF;
          else if (neg_q && grad_q[31]) grad_q <= 32'h8000_0000;
          else grad_q <= neg_q ? (32'd0 - grad_q) : grad_q;
          if ({1'b0, cnt_q} + 12'd1 >= {1'b0, n_q}) begin
            cnt_q <= '0; sum_q <= '0;
            num_q <= s; rem_q <= '0; den_q <= {10'd0, n_q, 8'd0}; bit_q <= 6'd40;
            state_q <= S_DIVL;
          end else begin
            sum_q <= s; cnt_q <= cnt_q + 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          ograd_q <= grad_q; oloss_q <= '0; olast_q <= 1'b0; ovalid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
